@@ hdl/tdl_pkg.sv @@
package tdl_pkg;

  localparam logic [1:0] OP_ACT   = 2'd0;
  localparam logic [1:0] OP_LEARN = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_DISCOUNT = 2'd1;
  localparam logic [1:0] REG_TERMINAL = 2'd2;

  localparam logic [15:0] DISCOUNT_RST = 16'd62259;

  typedef enum logic [1:0] {ROW_S, ROW_NS, ROW_PREV} row_sel_t;
  typedef enum logic [1:0] {COL_A, COL_X, COL_RA, COL_PREV} col_sel_t;
  typedef enum logic [1:0] {WD_UPD, WD_ITEM, WD_ZERO} wd_sel_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        discount;
    logic signed [31:0] terminal;
  } cfg_regs_t;

  typedef struct packed {
    logic     ld_item;
    logic     rd_en;
    logic     wr_en;
    wd_sel_t  wd_sel;
    row_sel_t row;
    col_sel_t col;
    logic     x_clr;
    logic     x_inc;
    logic     clr_inc;
    logic     scan;
    logic     ld_q;
    logic     nq_mem;
    logic     nq_best;
    logic     mul1;
    logic     td_upd;
    logic     use_prev;
    logic     td_term;
    logic     mul2;
    logic     prev_upd;
    logic     out_ld;
    logic     out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       done;
    logic       start;
    logic       explore;
    logic       prev_valid;
    logic       x_last;
    logic       clr_last;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] res;
    if (v > 36'sd2147483647) res = 32'sh7fffffff;
    else if (v < -36'sd2147483648) res = 32'sh80000000;
    else res = v[31:0];
    return res;
  endfunction

endpackage

@@ hdl/tabular_td_learning_engine.sv @@
// channel | signals                                   | transfer when
// input   | in_valid, in_stall, in_<field>            | in_valid && !in_stall
// result  | out_valid, out_stall, out_<field>         | out_valid && !out_stall
// config  | cfg_psel/penable/pwrite/paddr/pwdata/...  | psel && penable && pwrite
// one item at a time through a single-port table and one shared multiplier;
// act does a row scan; learn items add td updates, and a done learn item adds
// a terminal pull over every action of the next state
// after reset a clearing pass zeroes all NUM_STATES*NUM_ACTIONS entries of the table
// a new item is taken while an earlier result still waits in the output register
module tabular_td_learning_engine
  import tdl_pkg::*;
#(
  parameter int NUM_STATES  = 64,
  parameter int NUM_ACTIONS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_state_index,
  input  logic [1:0]         in_action_taken,
  input  logic signed [31:0] in_reward,
  input  logic [5:0]         in_next_state_index,
  input  logic               in_done_req,
  input  logic               in_episode_start,
  input  logic [15:0]        in_learn_rate,
  input  logic [15:0]        in_explore_rate,
  input  logic [15:0]        in_random_fraction,
  input  logic [1:0]         in_random_action,
  input  logic signed [31:0] in_write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_chosen_action,
  output logic signed [31:0] out_best_value,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_regs_t cfg_r;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= 1'b0;
      cfg_r.discount <= DISCOUNT_RST;
      cfg_r.terminal <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MODE:     cfg_r.mode     <= cfg_pwdata[0];
        REG_DISCOUNT: cfg_r.discount <= cfg_pwdata[15:0];
        REG_TERMINAL: cfg_r.terminal <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE:     cfg_prdata = {31'd0, cfg_r.mode};
      REG_DISCOUNT: cfg_prdata = {16'd0, cfg_r.discount};
      REG_TERMINAL: cfg_prdata = cfg_r.terminal;
      default:      cfg_prdata = '0;
    endcase
  end

  tdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (cfg_r.mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tdl_dpath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_opcode),
    .in_state_index      (in_state_index),
    .in_action_taken     (in_action_taken),
    .in_reward           (in_reward),
    .in_next_state_index (in_next_state_index),
    .in_done_req         (in_done_req),
    .in_episode_start    (in_episode_start),
    .in_learn_rate       (in_learn_rate),
    .in_explore_rate     (in_explore_rate),
    .in_random_fraction  (in_random_fraction),
    .in_random_action    (in_random_action),
    .in_write_value      (in_write_value),
    .out_chosen_action   (out_chosen_action),
    .out_best_value      (out_best_value)
  );

endmodule

@@ hdl/tdl_ctrl.sv @@
module tdl_ctrl
  import tdl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     mode,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_SCAN, S_SCANW, S_QL, S_T1, S_T2, S_T3, S_T4,
    S_SA, S_SB, S_SD, S_SE, S_P0, S_P1, S_P2, S_P3, S_P4, S_FIN
  } state_t;

  state_t   state_r, state_nxt;
  row_sel_t row_r, row_nxt;
  logic     sret_r, sret_nxt;   // after scan: 1 update current entry, 0 finish
  logic     tprev_r, tprev_nxt; // td target is the pending sarsa entry
  logic     zero_r, zero_nxt;
  logic     out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    row_nxt       = row_r;
    sret_nxt      = sret_r;
    tprev_nxt     = tprev_r;
    zero_nxt      = zero_r;
    unique case (state_r)
      S_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wd_sel  = WD_ZERO;
        cmd.clr_inc = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        zero_nxt = 1'b0;
        case (stat.opcode)
          OP_WRITE: begin
            cmd.wr_en  = 1'b1;
            cmd.wd_sel = WD_ITEM;
            cmd.row    = ROW_S;
            cmd.col    = COL_A;
            zero_nxt   = 1'b1;
            state_nxt  = S_FIN;
          end
          OP_ACT: begin
            cmd.x_clr = 1'b1;
            row_nxt   = ROW_S;
            sret_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
          OP_LEARN: begin
            if (!mode) begin
              cmd.x_clr = 1'b1;
              row_nxt   = ROW_NS;
              sret_nxt  = 1'b1;
              state_nxt = S_SCAN;
            end else if (!stat.start && stat.prev_valid) begin
              state_nxt = S_SA;
            end else begin
              state_nxt = S_SD;
            end
          end
          default: begin
            zero_nxt  = 1'b1;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.scan  = 1'b1;
        cmd.row   = row_r;
        cmd.col   = COL_X;
        cmd.x_inc = 1'b1;
        if (stat.x_last) state_nxt = S_SCANW;
      end
      S_SCANW: state_nxt = sret_r ? S_QL : S_FIN;
      S_QL: begin
        cmd.nq_best = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.row     = ROW_S;
        cmd.col     = COL_A;
        tprev_nxt   = 1'b0;
        state_nxt   = S_T1;
      end
      S_T1: begin
        cmd.ld_q  = 1'b1;
        cmd.mul1  = 1'b1;
        state_nxt = S_T2;
      end
      S_T2: begin
        cmd.td_upd   = 1'b1;
        cmd.use_prev = tprev_r;
        state_nxt    = S_T3;
      end
      S_T3: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_T4;
      end
      S_T4: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = WD_UPD;
        cmd.row    = tprev_r ? ROW_PREV : ROW_S;
        cmd.col    = tprev_r ? COL_PREV : COL_A;
        cmd.x_clr  = 1'b1;
        if (tprev_r) begin
          state_nxt = S_SD;
        end else if (stat.done) begin
          state_nxt = S_P0;
        end else begin
          row_nxt   = ROW_NS;
          sret_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SA: begin
        cmd.rd_en = 1'b1;
        cmd.row   = ROW_S;
        cmd.col   = COL_A;
        state_nxt = S_SB;
      end
      S_SB: begin
        cmd.nq_mem = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.row    = ROW_PREV;
        cmd.col    = COL_PREV;
        tprev_nxt  = 1'b1;
        state_nxt  = S_T1;
      end
      S_SD: begin
        cmd.prev_upd = 1'b1;
        cmd.x_clr    = 1'b1;
        row_nxt      = ROW_NS;
        if (stat.done && stat.explore) begin
          cmd.rd_en = 1'b1;
          cmd.row   = ROW_NS;
          cmd.col   = COL_RA;
          state_nxt = S_SE;
        end else begin
          sret_nxt  = stat.done;
          state_nxt = S_SCAN;
        end
      end
      S_SE: begin
        cmd.nq_mem = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.row    = ROW_S;
        cmd.col    = COL_A;
        tprev_nxt  = 1'b0;
        state_nxt  = S_T1;
      end
      S_P0: begin
        cmd.rd_en = 1'b1;
        cmd.row   = ROW_NS;
        cmd.col   = COL_X;
        state_nxt = S_P1;
      end
      S_P1: begin
        cmd.ld_q  = 1'b1;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.td_term = 1'b1;
        state_nxt   = S_P3;
      end
      S_P3: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_P4;
      end
      S_P4: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = WD_UPD;
        cmd.row    = ROW_NS;
        cmd.col    = COL_X;
        if (stat.x_last) begin
          cmd.x_clr = 1'b1;
          row_nxt   = ROW_NS;
          sret_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          cmd.x_inc = 1'b1;
          state_nxt = S_P0;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld   = 1'b1;
          cmd.out_zero = zero_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || cmd.out_ld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      row_r       <= ROW_S;
      sret_r      <= 1'b0;
      tprev_r     <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      sret_r      <= sret_nxt;
      tprev_r     <= tprev_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/tdl_dpath.sv @@
module tdl_dpath
  import tdl_pkg::*;
#(
  parameter int NUM_STATES  = 64,
  parameter int NUM_ACTIONS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_regs_t          cfg,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_state_index,
  input  logic [1:0]         in_action_taken,
  input  logic signed [31:0] in_reward,
  input  logic [5:0]         in_next_state_index,
  input  logic               in_done_req,
  input  logic               in_episode_start,
  input  logic [15:0]        in_learn_rate,
  input  logic [15:0]        in_explore_rate,
  input  logic [15:0]        in_random_fraction,
  input  logic [1:0]         in_random_action,
  input  logic signed [31:0] in_write_value,
  output logic [1:0]         out_chosen_action,
  output logic signed [31:0] out_best_value
);

  localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW    = $clog2(NUM_ACTIONS);
  localparam int TW    = $clog2(DEPTH);

  // item
  logic [1:0]         opc_r;
  logic [5:0]         s_r, ns_r;
  logic [1:0]         a_r, ra_r;
  logic signed [31:0] r_r, wv_r;
  logic               done_r, start_r;
  logic [15:0]        lr_r, eps_r, rf_r;

  // sarsa history
  logic [SW-1:0]      prev_s_r;
  logic [AW-1:0]      prev_a_r;
  logic signed [31:0] prev_r_r;
  logic               prev_valid_r;

  logic [AW-1:0]      x_r, xd_r;
  logic [TW-1:0]      clr_r;
  logic               sc_v_r, sc_first_r;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic signed [31:0] q_r, nq_r, best_r;
  logic [AW-1:0]      bidx_r;
  logic signed [33:0] td_r;
  logic signed [50:0] prod_r;

  logic [SW-1:0] smod_tbl [64];
  logic [AW-1:0] amod_tbl [4];

  for (genvar i = 0; i < 64; i++) begin : g_smod
    assign smod_tbl[i] = SW'(i % NUM_STATES);
  end
  for (genvar j = 0; j < 4; j++) begin : g_amod
    assign amod_tbl[j] = AW'(j % NUM_ACTIONS);
  end

  logic [SW-1:0]      row;
  logic [AW-1:0]      col;
  logic [TW-1:0]      addr, waddr;
  logic signed [31:0] wdata;
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] prod_c;
  logic signed [35:0] prod_sh, upd_sum, td_sum, term_sum, r_sel;
  logic               explore;

  assign explore = (rf_r < eps_r);

  always_comb begin
    case (cmd.row)
      ROW_S:    row = smod_tbl[s_r];
      ROW_NS:   row = smod_tbl[ns_r];
      ROW_PREV: row = prev_s_r;
      default:  row = '0;
    endcase
    case (cmd.col)
      COL_A:    col = amod_tbl[a_r];
      COL_X:    col = x_r;
      COL_RA:   col = amod_tbl[ra_r];
      default:  col = prev_a_r;
    endcase
  end

  assign addr  = TW'(row) * TW'(NUM_ACTIONS) + TW'(col);
  assign waddr = (cmd.wd_sel == WD_ZERO) ? clr_r : addr;

  // floor of the product over 65536, sign kept
  assign prod_sh  = 36'($signed(prod_r[50:16]));
  assign upd_sum  = 36'(q_r) + prod_sh;
  assign r_sel    = cmd.use_prev ? 36'(prev_r_r) : 36'(r_r);
  assign td_sum   = r_sel + prod_sh - 36'(q_r);
  assign term_sum = 36'(cfg.terminal) - 36'(q_r);

  always_comb begin
    case (cmd.wd_sel)
      WD_ITEM: wdata = wv_r;
      WD_ZERO: wdata = '0;
      default: wdata = sat32(upd_sum);
    endcase
  end

  // one multiplier: value times discount, then td times learn rate
  assign mul_a  = cmd.mul1 ? 34'(nq_r) : td_r;
  assign mul_b  = cmd.mul1 ? $signed({1'b0, cfg.discount}) : $signed({1'b0, lr_r});
  assign prod_c = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      opc_r   <= in_opcode;
      s_r     <= in_state_index;
      a_r     <= in_action_taken;
      r_r     <= in_reward;
      ns_r    <= in_next_state_index;
      done_r  <= in_done_req;
      start_r <= in_episode_start;
      lr_r    <= in_learn_rate;
      eps_r   <= in_explore_rate;
      rf_r    <= in_random_fraction;
      ra_r    <= in_random_action;
      wv_r    <= in_write_value;
    end
    if (cmd.prev_upd) begin
      prev_s_r <= smod_tbl[s_r];
      prev_a_r <= amod_tbl[a_r];
      prev_r_r <= r_r;
    end
    xd_r <= x_r;
    if (sc_v_r && (sc_first_r || rdata_r > best_r)) begin
      best_r <= rdata_r;
      bidx_r <= xd_r;
    end
    if (cmd.ld_q) q_r <= rdata_r;
    if (cmd.nq_mem) nq_r <= rdata_r;
    else if (cmd.nq_best) nq_r <= best_r;
    if (cmd.td_upd) td_r <= td_sum[33:0];
    else if (cmd.td_term) td_r <= term_sum[33:0];
    if (cmd.mul1 || cmd.mul2) prod_r <= prod_c;
    if (cmd.out_ld) begin
      if (cmd.out_zero) begin
        out_chosen_action <= '0;
        out_best_value    <= '0;
      end else begin
        out_chosen_action <= explore ? 2'(amod_tbl[ra_r]) : 2'(bidx_r);
        out_best_value    <= best_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      x_r          <= '0;
      clr_r        <= '0;
      sc_v_r       <= 1'b0;
      sc_first_r   <= 1'b0;
    end else begin
      if (cmd.prev_upd) prev_valid_r <= !done_r;
      if (cmd.x_clr) x_r <= '0;
      else if (cmd.x_inc) x_r <= x_r + 1'b1;
      if (cmd.clr_inc) clr_r <= clr_r + 1'b1;
      sc_v_r     <= cmd.scan;
      sc_first_r <= cmd.scan && (x_r == '0);
    end
  end

  always_comb begin
    stat.opcode     = opc_r;
    stat.done       = done_r;
    stat.start      = start_r;
    stat.explore    = explore;
    stat.prev_valid = prev_valid_r;
    stat.x_last     = (x_r == AW'(NUM_ACTIONS - 1));
    stat.clr_last   = (clr_r == TW'(DEPTH - 1));
  end

endmodule

@@ tb/sv/tabular_td_learning_engine_tb.sv @@
`timescale 1ns / 1ps

module tabular_td_learning_engine_tb;
  import tdl_pkg::*;

  localparam int N_S = 64;
  localparam int N_A = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         opcode;
    logic [5:0]         s;
    logic [1:0]         a;
    logic signed [31:0] reward;
    logic [5:0]         ns;
    logic               done;
    logic               start;
    logic [15:0]        lr;
    logic [15:0]        eps;
    logic [15:0]        u;
    logic [1:0]         ra;
    logic signed [31:0] wval;
  } td_item_t;

  typedef struct {
    logic [1:0]         action;
    logic signed [31:0] best;
  } td_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [5:0] in_state_index = '0;
  logic [1:0] in_action_taken = '0;
  logic signed [31:0] in_reward = '0;
  logic [5:0] in_next_state_index = '0;
  logic in_done_req = 1'b0;
  logic in_episode_start = 1'b0;
  logic [15:0] in_learn_rate = '0;
  logic [15:0] in_explore_rate = '0;
  logic [15:0] in_random_fraction = '0;
  logic [1:0] in_random_action = '0;
  logic signed [31:0] in_write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_chosen_action;
  logic signed [31:0] out_best_value;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  tabular_td_learning_engine u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  logic signed [31:0] qtab [N_S*N_A];
  logic [5:0]  m_prev_s;
  logic [1:0]  m_prev_a;
  logic signed [31:0] m_prev_r;
  logic        m_prev_valid;
  logic        m_mode;
  logic [15:0] m_discount;
  logic signed [31:0] m_terminal;

  td_result_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_learn = 0;
  bit hold_rx = 1'b0;

  function automatic longint frac_mul(longint v, logic [15:0] f);
    longint p;
    p = v * longint'({16'd0, f});
    return p >>> 16;  // arithmetic shift floors toward minus infinity
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] row_best(logic [5:0] s, output logic [1:0] idx);
    logic signed [31:0] b;
    b = qtab[s*N_A];
    idx = 2'd0;
    for (int x = 1; x < N_A; x++)
      if (qtab[s*N_A+x] > b) begin
        b = qtab[s*N_A+x];
        idx = x[1:0];
      end
    return b;
  endfunction

  function automatic void td_apply(int c, longint r, longint nq, logic [15:0] lr);
    longint td;
    td = r + frac_mul(nq, m_discount) - longint'(qtab[c]);
    qtab[c] = clip32(longint'(qtab[c]) + frac_mul(td, lr));
  endfunction

  function automatic void pull_terminal(logic [5:0] s, logic [15:0] lr);
    longint q;
    for (int x = 0; x < N_A; x++) begin
      q = qtab[s*N_A+x];
      qtab[s*N_A+x] = clip32(q + frac_mul(longint'(m_terminal) - q, lr));
    end
  endfunction

  function automatic td_result_t predict_choice(td_item_t it);
    td_result_t res;
    logic [1:0] bi;
    logic signed [31:0] m;
    logic [5:0] row;
    logic explore;
    int cur;
    res.action = 2'd0;
    res.best = '0;
    explore = it.u < it.eps;
    row = it.s;
    if (it.opcode == OP_WRITE) begin
      qtab[it.s*N_A+it.a] = it.wval;
      return res;
    end
    if (it.opcode == OP_UNUSED) return res;
    if (it.opcode == OP_LEARN) begin
      cur = it.s*N_A + it.a;
      row = it.ns;
      if (!m_mode) begin
        m = row_best(it.ns, bi);
        td_apply(cur, it.reward, m, it.lr);
        if (it.done) pull_terminal(it.ns, it.lr);
      end else begin
        if (!it.start && m_prev_valid)
          td_apply(m_prev_s*N_A+m_prev_a, m_prev_r, qtab[cur], it.lr);
        if (it.done) begin
          if (explore) m = qtab[it.ns*N_A+it.ra];
          else m = row_best(it.ns, bi);
          td_apply(cur, it.reward, m, it.lr);
          pull_terminal(it.ns, it.lr);
        end
        m_prev_s = it.s;
        m_prev_a = it.a;
        m_prev_r = it.reward;
        m_prev_valid = !it.done;
      end
    end
    res.best = row_best(row, bi);
    res.action = explore ? it.ra : bi;
    return res;
  endfunction

  // valid drops only when a gap follows; the queue drain drops it at the end
  task automatic send_item(td_item_t it);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_q.insert(expected_q.size(), predict_choice(it));
    if (it.opcode == OP_LEARN) n_learn++;
    in_valid <= 1'b1;
    in_opcode <= it.opcode;
    in_state_index <= it.s;
    in_action_taken <= it.a;
    in_reward <= it.reward;
    in_next_state_index <= it.ns;
    in_done_req <= it.done;
    in_episode_start <= it.start;
    in_learn_rate <= it.lr;
    in_explore_rate <= it.eps;
    in_random_fraction <= it.u;
    in_random_action <= it.ra;
    in_write_value <= it.wval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MODE:     m_mode = val[0];
      REG_DISCOUNT: m_discount = val[15:0];
      REG_TERMINAL: m_terminal = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic mode, logic [15:0] disc, logic signed [31:0] term);
    wait_drain();
    cfg_write(REG_MODE, {31'd0, mode});
    cfg_write(REG_DISCOUNT, {16'd0, disc});
    cfg_write(REG_TERMINAL, term);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 8) <<< 16;
      3: return -($urandom_range(0, 8) <<< 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic td_item_t rand_item(logic [1:0] op);
    td_item_t it;
    it.opcode = op;
    it.s = 6'($urandom);
    it.a = 2'($urandom);
    it.reward = pick_value();
    it.ns = 6'($urandom);
    it.done = ($urandom_range(0, 5) == 0);
    it.start = ($urandom_range(0, 7) == 0);
    it.lr = pick_frac();
    it.eps = pick_frac();
    it.u = 16'($urandom);
    it.ra = 2'($urandom);
    it.wval = pick_value();
    return it;
  endfunction

  task automatic test_directed();
    td_item_t it;
    it = rand_item(OP_ACT);
    it.s = 6'd0; it.eps = 16'd0; it.u = 16'd0;
    send_item(it);
    it = rand_item(OP_WRITE); it.s = 6'd63; it.a = 2'd3; it.wval = 32'sh7fffffff;
    send_item(it);
    it = rand_item(OP_WRITE); it.s = 6'd63; it.a = 2'd1; it.wval = 32'sh7fffffff;
    send_item(it);
    it = rand_item(OP_WRITE); it.s = 6'd0; it.a = 2'd0; it.wval = 32'sh80000000;
    send_item(it);
    // ties resolve to the lowest index
    it = rand_item(OP_ACT); it.s = 6'd63; it.eps = 16'd0; it.u = 16'hffff;
    send_item(it);
    // explore forced
    it = rand_item(OP_ACT); it.s = 6'd63; it.eps = 16'hffff; it.u = 16'd0; it.ra = 2'd2;
    send_item(it);
    // saturating learn up and down
    it = rand_item(OP_LEARN); it.s = 6'd63; it.a = 2'd3; it.ns = 6'd63;
    it.reward = 32'sh7fffffff; it.lr = 16'hffff; it.done = 1'b0;
    send_item(it);
    it = rand_item(OP_LEARN); it.s = 6'd0; it.a = 2'd0; it.ns = 6'd0;
    it.reward = 32'sh80000000; it.lr = 16'hffff; it.done = 1'b1;
    send_item(it);
    it = rand_item(OP_LEARN); it.lr = 16'd0;
    send_item(it);
    it = rand_item(OP_UNUSED);
    send_item(it);
    set_config(1'b1, 16'hffff, 32'sh7fffffff);
    for (int k = 0; k < 6; k++) begin
      it = rand_item(OP_LEARN);
      it.start = (k == 0);
      it.done = (k == 5);
      it.lr = 16'hffff;
      it.eps = (k == 5) ? 16'hffff : 16'h0;
      it.u = 16'd0;
      send_item(it);
    end
    set_config(1'b0, 16'd0, 32'sh80000000);
    send_item(rand_item(OP_LEARN));
    it = rand_item(OP_LEARN); it.done = 1'b1; send_item(it);
  endtask

  task automatic test_episodes(int count, logic mode);
    td_item_t it;
    logic [5:0] cur_s;
    int len;
    int k;
    k = 0;
    while (k < count) begin
      len = $urandom_range(2, 10);
      cur_s = 6'($urandom);
      for (int j = 0; j < len && k < count; j++) begin
        case ($urandom_range(0, 9))
          0: it = rand_item(OP_WRITE);
          1: it = rand_item(OP_ACT);
          2: it = rand_item(OP_UNUSED);
          default: begin
            it = rand_item(OP_LEARN);
            it.s = cur_s;
            it.start = (j == 0) || ($urandom_range(0, 30) == 0);
            it.done = (j == len - 1);
            cur_s = it.ns;
          end
        endcase
        if ($urandom_range(0, 15) == 0 && !mode) it.done = 1'b1;
        send_item(it);
        k++;
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      test_episodes(20, 1'b0);
    join
    wait_drain();
  endtask

  // receiver stall per result
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      w = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) w = 0;
      if ((w != 0) || hold_rx) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) begin
        if (hold_rx) break;
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    td_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result action=%0d best=%0d", $time,
                 out_chosen_action, out_best_value);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_chosen_action !== e.action) begin
          $display("%0t chosen_action expected %0d actual %0d", $time, e.action,
                   out_chosen_action);
          errors++;
        end
        if (out_best_value !== e.best) begin
          $display("%0t best_value expected %0d actual %0d", $time, e.best,
                   out_best_value);
          errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int i = 0; i < N_S*N_A; i++) qtab[i] = '0;
    m_prev_s = '0; m_prev_a = '0; m_prev_r = '0; m_prev_valid = 1'b0;
    m_mode = 1'b0; m_discount = DISCOUNT_RST; m_terminal = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    set_config(1'b0, DISCOUNT_RST, 32'sh00010000);
    test_episodes(500, 1'b0);
    set_config(1'b1, 16'd32768, -32'sh00020000);
    test_episodes(500, 1'b1);
    set_config(1'b1, 16'd0, 32'sh7fffffff);
    test_episodes(250, 1'b1);
    set_config(1'b0, 16'hffff, 32'sh80000000);
    test_episodes(250, 1'b0);
    wait_drain();
    if (expected_q.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, expected_q.size());
      errors++;
    end
    $display("covered %0d results, %0d learn items, both update modes", n_results, n_learn);
    $display("register extremes, table saturation and output hold-off exercised");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
